/* hdl/lmbp_pkg.sv */
// Package: phase codes, beat types and constants of the layout message byte parser.
package lmbp_pkg;

   localparam int unsigned DATA_BYTE_WIDTH  = 8;
   localparam int unsigned NODE_IDENT_WIDTH = 32;
   localparam int unsigned HALF_WIDTH       = 16;
   localparam int unsigned GROUP_BITS       = 7;

   localparam logic [DATA_BYTE_WIDTH-1:0] OPCODE_LAYOUT_SET = 8'h41;
   localparam logic [DATA_BYTE_WIDTH-1:0] GROUP_MASK        = 8'h7F;
   localparam logic [DATA_BYTE_WIDTH-1:0] MORE_FLAG         = 8'h80;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SKIP,
      PH_IDENT,
      PH_XH,
      PH_XL,
      PH_YH,
      PH_YL,
      PH_WH,
      PH_WL,
      PH_HH,
      PH_HL
   } phase_type;

   typedef struct packed {
      logic [NODE_IDENT_WIDTH-1:0] node_ident;
      logic signed [HALF_WIDTH-1:0] pos_x;
      logic signed [HALF_WIDTH-1:0] pos_y;
      logic [HALF_WIDTH-1:0]        size_w;
      logic [HALF_WIDTH-1:0]        size_h;
   } rsp_data_type;

endpackage

/* hdl/lmbp_if.sv */
// Interfaces: byte request channel and layout result channel.
interface lmbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       msg_start;

   modport source (output valid, output data_byte, output msg_start, input ready);
   modport sink (input valid, input data_byte, input msg_start, output ready);
endinterface

interface lmbp_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        node_ident;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [15:0]        size_w;
   logic [15:0]        size_h;

   modport source (output valid, output node_ident, output pos_x, output pos_y,
                   output size_w, output size_h, input ready);
   modport sink (input valid, input node_ident, input pos_x, input pos_y,
                 input size_w, input size_h, output ready);
endinterface

/* hdl/lmbp_parser.sv */
// Parser: phase machine, LEB128 identifier accumulator and field holds.
module lmbp_parser
   import lmbp_pkg::*;
#(
   parameter int unsigned IDENT_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       beat_accept,
   input  logic [DATA_BYTE_WIDTH-1:0] data_byte,
   input  logic                       msg_start,
   output logic                       emit,
   output rsp_data_type               emit_data
);

   localparam int unsigned GROUP_LIMIT = (IDENT_WIDTH + GROUP_BITS - 1) / GROUP_BITS;
   localparam int unsigned CNT_W       = $clog2(GROUP_LIMIT + 1);
   localparam int unsigned SH_W        = $clog2(GROUP_LIMIT * GROUP_BITS + 1);

   phase_type                  phase_ff, phase_in;
   logic [IDENT_WIDTH-1:0]     accum_ff, accum_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [DATA_BYTE_WIDTH-1:0] high_ff, high_in;
   logic [HALF_WIDTH-1:0]      x_ff, x_in;
   logic [HALF_WIDTH-1:0]      y_ff, y_in;
   logic [HALF_WIDTH-1:0]      w_ff, w_in;

   logic [SH_W-1:0]            shift_amt;
   logic [IDENT_WIDTH-1:0]     group_part;
   logic [HALF_WIDTH-1:0]      joined;
   logic [NODE_IDENT_WIDTH-1:0] ident_out;

   assign shift_amt  = SH_W'(count_ff) * SH_W'(GROUP_BITS);
   assign group_part = {{(IDENT_WIDTH-GROUP_BITS){1'b0}},
                        data_byte[GROUP_BITS-1:0] & GROUP_MASK[GROUP_BITS-1:0]} << shift_amt;
   assign joined     = {high_ff, data_byte};

   generate
      if (IDENT_WIDTH >= NODE_IDENT_WIDTH) begin : g_ident_trunc
         assign ident_out = accum_ff[NODE_IDENT_WIDTH-1:0];
      end else begin : g_ident_ext
         assign ident_out = {{(NODE_IDENT_WIDTH-IDENT_WIDTH){1'b0}}, accum_ff};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         accum_ff <= '0;
         count_ff <= '0;
         high_ff  <= '0;
         x_ff     <= '0;
         y_ff     <= '0;
         w_ff     <= '0;
      end else begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
         high_ff  <= high_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         w_ff     <= w_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      count_in  = count_ff;
      high_in   = high_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      w_in      = w_ff;
      emit      = 1'b0;
      emit_data.node_ident = ident_out;
      emit_data.pos_x      = x_ff;
      emit_data.pos_y      = y_ff;
      emit_data.size_w     = w_ff;
      emit_data.size_h     = joined;
      if (beat_accept) begin
         if (msg_start) begin
            accum_in = '0;
            count_in = '0;
            high_in  = '0;
            phase_in = (data_byte == OPCODE_LAYOUT_SET) ? PH_IDENT : PH_SKIP;
         end else begin
            case (phase_ff)
               PH_IDENT: begin
                  if (count_ff < CNT_W'(GROUP_LIMIT)) begin
                     accum_in = accum_ff | group_part;
                     count_in = count_ff + CNT_W'(1);
                  end
                  if ((data_byte & MORE_FLAG) == '0) begin
                     phase_in = PH_XH;
                  end
               end
               PH_XH: begin
                  high_in  = data_byte;
                  phase_in = PH_XL;
               end
               PH_XL: begin
                  x_in     = joined;
                  phase_in = PH_YH;
               end
               PH_YH: begin
                  high_in  = data_byte;
                  phase_in = PH_YL;
               end
               PH_YL: begin
                  y_in     = joined;
                  phase_in = PH_WH;
               end
               PH_WH: begin
                  high_in  = data_byte;
                  phase_in = PH_WL;
               end
               PH_WL: begin
                  w_in     = joined;
                  phase_in = PH_HH;
               end
               PH_HH: begin
                  high_in  = data_byte;
                  phase_in = PH_HL;
               end
               PH_HL: begin
                  emit     = 1'b1;
                  phase_in = PH_IDLE;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

endmodule

/* hdl/lmbp_out_reg.sv */
// Output register: holds one result beat until the sink takes it.
module lmbp_out_reg
   import lmbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_data_type load_data,
   input  logic         out_ready,
   output logic         out_valid,
   output rsp_data_type out_data,
   output logic         space
);

   logic         valid_ff, valid_in;
   rsp_data_type data_ff, data_in;

   assign space     = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

/* hdl/layout_message_byte_parser.sv */
// Top level: layout message byte parser with registered result channel.
//
//   channel   dir   payload                                   handshake
//   req_chan  in    data_byte[8], msg_start                   valid/ready
//   rsp_chan  out   node_ident[32], pos_x, pos_y, size_w/h    valid/ready
//
// One byte per cycle while req_chan.ready is high; each taken byte reaches the phase machine in the cycle it is taken.
// A result appears on rsp_chan the cycle after the final height byte.
// req_chan.ready drops only while a result waits and rsp_chan.ready is low.
// Reset is synchronous and returns the parser to idle with an empty output.
module layout_message_byte_parser
   import lmbp_pkg::*;
#(
   parameter int unsigned IDENT_WIDTH = 32
) (
   input  logic   clock,
   input  logic   reset,
   lmbp_req_if.sink   req_chan,
   lmbp_rsp_if.source rsp_chan
);

   logic         beat_accept;
   logic         emit;
   logic         space;
   rsp_data_type emit_data;
   rsp_data_type out_data;

   assign req_chan.ready = space;
   assign beat_accept    = req_chan.valid && space;

   lmbp_parser #(
      .IDENT_WIDTH (IDENT_WIDTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .data_byte   (req_chan.data_byte),
      .msg_start   (req_chan.msg_start),
      .emit        (emit),
      .emit_data   (emit_data)
   );

   lmbp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_data (emit_data),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_data  (out_data),
      .space     (space)
   );

   assign rsp_chan.node_ident = out_data.node_ident;
   assign rsp_chan.pos_x      = out_data.pos_x;
   assign rsp_chan.pos_y      = out_data.pos_y;
   assign rsp_chan.size_w     = out_data.size_w;
   assign rsp_chan.size_h     = out_data.size_h;

endmodule

/* verif/tb_layout_message_byte_parser.sv */
// Testbench for the layout message byte parser: byte stimulus, layout prediction and checks.
module tb_layout_message_byte_parser
   import lmbp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned GROUP_LIMIT = (NODE_IDENT_WIDTH + GROUP_BITS - 1) / GROUP_BITS;
   localparam int unsigned LAYOUT_QUOTA = 1500;
   localparam int unsigned HOLD_CYCLES = 400;

   class layout_tracker;
      phase_type    phase;
      logic [31:0]  ident_sum;
      int unsigned  groups_taken;
      logic [7:0]   high_hold;
      logic [15:0]  x_val;
      logic [15:0]  y_val;
      logic [15:0]  w_val;
      rsp_data_type pending_layouts[$];
      int unsigned  mismatches;

      function new();
         phase        = PH_IDLE;
         ident_sum    = '0;
         groups_taken = 0;
         high_hold    = '0;
         x_val        = '0;
         y_val        = '0;
         w_val        = '0;
         mismatches   = 0;
      endfunction

      task report(input string what);
         if (mismatches < 100) $display("mismatch: %s", what);
         mismatches++;
      endtask

      function void note_byte(input logic [7:0] b, input logic start);
         rsp_data_type layout;
         int unsigned  shift;
         if (start) begin
            ident_sum    = '0;
            groups_taken = 0;
            high_hold    = '0;
            phase        = (b == OPCODE_LAYOUT_SET) ? PH_IDENT : PH_SKIP;
            return;
         end
         case (phase)
            PH_IDENT: begin
               shift = groups_taken * GROUP_BITS;
               if (shift < NODE_IDENT_WIDTH)
                  ident_sum = ident_sum | (32'(b & GROUP_MASK) << shift);
               if (groups_taken < GROUP_LIMIT) groups_taken++;
               if ((b & MORE_FLAG) == 0) phase = PH_XH;
            end
            PH_XH: begin high_hold = b; phase = PH_XL; end
            PH_YH: begin high_hold = b; phase = PH_YL; end
            PH_WH: begin high_hold = b; phase = PH_WL; end
            PH_HH: begin high_hold = b; phase = PH_HL; end
            PH_XL: begin x_val = {high_hold, b}; phase = PH_YH; end
            PH_YL: begin y_val = {high_hold, b}; phase = PH_WH; end
            PH_WL: begin w_val = {high_hold, b}; phase = PH_HH; end
            PH_HL: begin
               layout.node_ident = ident_sum;
               layout.pos_x      = x_val;
               layout.pos_y      = y_val;
               layout.size_w     = w_val;
               layout.size_h     = {high_hold, b};
               pending_layouts.push_back(layout);
               phase = PH_IDLE;
            end
            default: ;
         endcase
      endfunction

      task check_layout(input rsp_data_type got);
         rsp_data_type want;
         if (pending_layouts.size() == 0) begin
            report($sformatf("unexpected layout, ident %h", got.node_ident));
            return;
         end
         want = pending_layouts.pop_front();
         if (got.node_ident !== want.node_ident)
            report($sformatf("node_ident %h, want %h", got.node_ident, want.node_ident));
         if (got.pos_x !== want.pos_x)
            report($sformatf("pos_x %0d, want %0d", got.pos_x, want.pos_x));
         if (got.pos_y !== want.pos_y)
            report($sformatf("pos_y %0d, want %0d", got.pos_y, want.pos_y));
         if (got.size_w !== want.size_w)
            report($sformatf("size_w %0d, want %0d", got.size_w, want.size_w));
         if (got.size_h !== want.size_h)
            report($sformatf("size_h %0d, want %0d", got.size_h, want.size_h));
      endtask

      task check_drained();
         if (pending_layouts.size() != 0)
            report($sformatf("%0d layouts never arrived", pending_layouts.size()));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   lmbp_req_if req_chan_i ();
   lmbp_rsp_if rsp_chan_i ();

   layout_message_byte_parser uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan_i.sink),
      .rsp_chan (rsp_chan_i.source)
   );

   layout_tracker tracker = new();

   int unsigned cycle_count = 0;
   int unsigned layout_bytes = 0;
   int unsigned burst_left = 0;
   bit          steady = 1'b0;
   bit          hold_request = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;
   int unsigned rx_mode = 0;
   int unsigned rx_mode_left = 0;
   int unsigned rx_step = 0;
   logic [7:0]  rx_pattern = 8'b1011_0110;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan_i.valid === 1'b1 && rsp_chan_i.ready === 1'b1)
         tracker.check_layout('{node_ident: rsp_chan_i.node_ident, pos_x: rsp_chan_i.pos_x,
                                pos_y: rsp_chan_i.pos_y, size_w: rsp_chan_i.size_w,
                                size_h: rsp_chan_i.size_h});
   end

   initial begin
      rsp_chan_i.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan_i.ready <= 1'b0;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode      = $urandom_range(0, 3);
               rx_mode_left = $urandom_range(20, 120);
            end
            rx_mode_left--;
            rx_step++;
            case (rx_mode)
               0: rsp_chan_i.ready <= 1'b1;
               1: rsp_chan_i.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan_i.ready <= ($urandom_range(0, 9) != 0);
               default: rsp_chan_i.ready <= rx_pattern[rx_step % 8];
            endcase
         end
      end
   end

   task automatic pace_sender();
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_chan_i.valid     <= 1'b0;
            req_chan_i.data_byte <= 8'($urandom);
            req_chan_i.msg_start <= 1'($urandom);
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic start);
      pace_sender();
      req_chan_i.valid     <= 1'b1;
      req_chan_i.data_byte <= b;
      req_chan_i.msg_start <= start;
      do @(posedge clock); while (req_chan_i.ready !== 1'b1);
      tracker.note_byte(b, start);
      @(negedge clock);
   endtask

   task automatic send_layout(input logic [63:0] ident, input int groups,
                              input logic [15:0] x, y, w, h, input int cut);
      logic [7:0] msg[$];
      int         count;
      msg.push_back(OPCODE_LAYOUT_SET);
      for (int i = 0; i < groups; i++)
         msg.push_back({1'(i < groups - 1), ident[7*i +: 7]});
      msg.push_back(x[15:8]);
      msg.push_back(x[7:0]);
      msg.push_back(y[15:8]);
      msg.push_back(y[7:0]);
      msg.push_back(w[15:8]);
      msg.push_back(w[7:0]);
      msg.push_back(h[15:8]);
      msg.push_back(h[7:0]);
      count = (cut < 0 || cut > msg.size()) ? msg.size() : cut;
      for (int i = 0; i < count; i++)
         send_byte(msg[i], i == 0);
      layout_bytes += count;
   endtask

   task automatic send_other(input logic [7:0] opcode, input int length);
      send_byte(opcode, 1'b1);
      repeat (length) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic send_noise(input int length);
      repeat (length) send_byte(8'($urandom), $urandom_range(0, 4) == 0);
   endtask

   function automatic logic [15:0] pick_half();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_opcode();
      logic [7:0] op;
      op = 8'($urandom);
      while (op == OPCODE_LAYOUT_SET) op = 8'($urandom);
      return op;
   endfunction

   initial begin
      int unsigned kind;
      int          groups;
      reset                = 1'b1;
      req_chan_i.valid     = 1'b0;
      req_chan_i.data_byte = '0;
      req_chan_i.msg_start = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_layout(64'h0, 1, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, -1);
      send_byte(OPCODE_LAYOUT_SET, 1'b0);
      send_layout({64{1'b1}}, 5, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, -1);
      send_layout({64{1'b1}}, 8, 16'hFFFF, 16'h0001, 16'h1234, 16'hABCD, -1);
      send_layout(64'h0123_4567_89AB_CDEF, 6, 16'h0F0F, 16'hF0F0, 16'h5555, 16'hAAAA, -1);
      send_other(8'h40, 12);
      send_other(8'hBE, 3);
      send_layout(64'h5A5A, 3, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 6);
      send_layout(64'hFFFF, 3, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 2);
      send_layout(64'h7F, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10);
      send_layout(64'h3FFF, 2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, -1);
      send_other(8'hC1, 0);
      send_layout(64'h1, 1, 16'h8001, 16'h7FFE, 16'h0100, 16'h00FF, -1);

      // random part
      while (layout_bytes < LAYOUT_QUOTA) begin
         steady = ($urandom_range(0, 3) == 0);
         if (layout_bytes > 700) hold_request <= 1'b1;
         kind   = $urandom_range(0, 99);
         groups = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 8);
         if (kind < 70)
            send_layout({$urandom, $urandom}, groups, pick_half(), pick_half(),
                        pick_half(), pick_half(), -1);
         else if (kind < 82)
            send_layout({$urandom, $urandom}, groups, pick_half(), pick_half(),
                        pick_half(), pick_half(), $urandom_range(1, groups + 8));
         else if (kind < 90)
            send_other(pick_opcode(), $urandom_range(0, 12));
         else
            send_noise($urandom_range(1, 8));
      end

      req_chan_i.valid <= 1'b0;
      while (tracker.pending_layouts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      tracker.check_drained();
      if (tracker.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
hdl/lmbp_pkg.sv
hdl/lmbp_if.sv
hdl/lmbp_parser.sv
hdl/lmbp_out_reg.sv
hdl/layout_message_byte_parser.sv
verif/tb_layout_message_byte_parser.sv
